// ===== hw/rtl/fis_pkg.sv =====
package fis_pkg;

  // Sequencer states of the statistics engine.
  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIV_MEAN,
    S_MEAN,
    S_ERR,
    S_MUL,
    S_ACC,
    S_DIV_VAR,
    S_SQRT,
    S_DIV_RATE,
    S_RATE,
    S_OUT
  } fis_state_t;

  // Width of the shared add/subtract unit: one guard bit above a 65-bit operand.
  localparam int unsigned ALU_W = 66;

  // Highest reportable rate: one gigahertz expressed in millihertz.
  localparam logic [63:0] RATE_MAX_MHZ = 64'd1000000000000;

  // Steps of the restoring divider (64-bit dividend) and of the square root.
  localparam logic [5:0] DIV_LAST = 6'd63;
  localparam logic [5:0] SQRT_LAST = 6'd31;

endpackage

// ===== hw/rtl/frame_interval_statistics.sv =====
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------------------
// in_      | input     | in_valid / in_stall  | in_timestamp_ns
// out_     | output    | out_valid / out_stall| interval_count, min, max, mean, stddev, rate
//
// One transaction occupies the block from one accepting edge to the next: the single shared
// 66-bit add/subtract unit serves three 64-step restoring divisions, an MW-step shift-add
// multiplication (MW = INTERVAL_BITS + MEAN_FRAC_BITS) and a 32-step square root in turn.
// A zero mean skips the rate division. The priming transaction goes straight to the output
// state.
// Reset is synchronous and active low; it clears the statistics and the sequencer.
// The block stalls its input while a transaction is in work; a finished result waits in the
// output register, so a stalled output only holds the sequencer in its final state.

module frame_interval_statistics
  import fis_pkg::*;
#(
  parameter int unsigned INTERVAL_BITS  = 32,
  parameter int unsigned COUNT_BITS     = 32,
  parameter int unsigned MEAN_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_timestamp_ns,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_interval_count,
  output logic [31:0] out_min_interval_ns,
  output logic [31:0] out_max_interval_ns,
  output logic [47:0] out_mean_interval,
  output logic [31:0] out_stddev_interval_ns,
  output logic [39:0] out_mean_rate_mhz
);

  // The mean carries the interval width plus its fraction; the product of two
  // deviations needs twice that.
  localparam int unsigned MW = INTERVAL_BITS + MEAN_FRAC_BITS;
  localparam int unsigned PW = 2 * MW;

  localparam logic [63:0] IV_MAX   = (64'(1) << INTERVAL_BITS) - 64'(1);
  localparam logic [63:0] RATE_NUM = RATE_MAX_MHZ << MEAN_FRAC_BITS;
  localparam logic [5:0]  MUL_LAST = 6'(MW - 1);

  fis_state_t state_r, state_nxt;

  // Statistics kept across transactions.
  logic                     primed_r, primed_nxt;
  logic [63:0]              last_r, last_nxt;
  logic [COUNT_BITS-1:0]    count_r, count_nxt;
  logic [INTERVAL_BITS-1:0] min_r, min_nxt;
  logic [INTERVAL_BITS-1:0] max_r, max_nxt;
  logic [MW-1:0]            mean_r, mean_nxt;
  logic [63:0]              sq_r, sq_nxt;

  // Working registers of one transaction.
  logic [INTERVAL_BITS-1:0] x_r, x_nxt;
  logic                     neg_r, neg_nxt;
  logic [MW-1:0]            d_r, d_nxt;
  logic [63:0]              dq_r, dq_nxt;
  logic [63:0]              rem_r, rem_nxt;
  logic [63:0]              den_r, den_nxt;
  logic [PW-1:0]            prod_r, prod_nxt;
  logic [63:0]              v_r, v_nxt;
  logic [63:0]              res_r, res_nxt;
  logic [5:0]               cnt_r, cnt_nxt;
  logic [31:0]              std_r, std_nxt;
  logic [39:0]              rate_r, rate_nxt;

  // Output register.
  logic        ov_r, ov_nxt;
  logic [31:0] o_count_r, o_count_nxt;
  logic [31:0] o_min_r, o_min_nxt;
  logic [31:0] o_max_r, o_max_nxt;
  logic [47:0] o_mean_r, o_mean_nxt;
  logic [31:0] o_std_r, o_std_nxt;
  logic [39:0] o_rate_r, o_rate_nxt;

  // The shared add/subtract unit.
  logic [ALU_W-1:0] alu_a, alu_b, alu_res;
  logic             alu_sub;
  logic             borrow;

  assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign borrow  = alu_res[ALU_W-1];

  logic        in_take;
  logic        out_take;
  logic        out_load;
  logic        step_last;
  logic [63:0] ts_diff;
  logic [63:0] x_wide;
  logic [MW-1:0] xq;
  logic [MW-1:0] step_q;
  logic [63:0] sq_bit;
  logic [127:0] prod_ext;
  logic [127:0] prod_sh;
  logic [63:0] sq_inc;
  logic [63:0] sq_sat;
  logic [64:0] div_shift;
  logic [63:0] div_q;
  logic [63:0] div_rem;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = ov_r && !out_stall;
  assign out_load  = (state_r == S_OUT) && (!ov_r || !out_stall);
  assign step_last = (cnt_r == 6'd0);

  // A timestamp that does not move forward gives a zero interval; a long one saturates.
  assign ts_diff = (in_timestamp_ns > last_r) ? (in_timestamp_ns - last_r) : 64'd0;
  assign x_wide  = (ts_diff > IV_MAX) ? IV_MAX : ts_diff;

  assign xq     = MW'(x_r) << MEAN_FRAC_BITS;
  assign step_q = MW'(dq_r);
  assign sq_bit = 64'(1) << {cnt_r[4:0], 1'b0};

  // The product is scaled back by both fraction widths and clipped to 64 bits.
  assign prod_ext = 128'(prod_r);
  assign prod_sh  = prod_ext >> (2 * MEAN_FRAC_BITS);
  assign sq_inc   = (|prod_sh[127:64]) ? '1 : prod_sh[63:0];
  assign sq_sat   = alu_res[64] ? '1 : alu_res[63:0];

  // One restoring division step: the partial remainder takes the next dividend bit,
  // and the divisor comes off when it fits.
  assign div_shift = {rem_r, dq_r[63]};
  assign div_q     = {dq_r[62:0], !borrow};
  assign div_rem   = borrow ? div_shift[63:0] : alu_res[63:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = primed_r ? S_PREP : S_OUT;
        end
      end
      S_PREP:     state_nxt = S_DIV_MEAN;
      S_DIV_MEAN: if (step_last) state_nxt = S_MEAN;
      S_MEAN:     state_nxt = S_ERR;
      S_ERR:      state_nxt = S_MUL;
      S_MUL:      if (step_last) state_nxt = S_ACC;
      S_ACC:      state_nxt = S_DIV_VAR;
      S_DIV_VAR:  if (step_last) state_nxt = S_SQRT;
      S_SQRT: begin
        if (step_last) begin
          state_nxt = (mean_r == '0) ? S_OUT : S_DIV_RATE;
        end
      end
      S_DIV_RATE: if (step_last) state_nxt = S_RATE;
      S_RATE:     state_nxt = S_OUT;
      S_OUT:      if (out_load) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath and operand selection for the shared unit.
  always_comb begin
    primed_nxt = primed_r;
    last_nxt   = last_r;
    count_nxt  = count_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    mean_nxt   = mean_r;
    sq_nxt     = sq_r;
    x_nxt      = x_r;
    neg_nxt    = neg_r;
    d_nxt      = d_r;
    dq_nxt     = dq_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    prod_nxt   = prod_r;
    v_nxt      = v_r;
    res_nxt    = res_r;
    cnt_nxt    = cnt_r;
    std_nxt    = std_r;
    rate_nxt   = rate_r;
    alu_a      = '0;
    alu_b      = '0;
    alu_sub    = 1'b1;
    ov_nxt      = out_take ? 1'b0 : ov_r;
    o_count_nxt = o_count_r;
    o_min_nxt   = o_min_r;
    o_max_nxt   = o_max_r;
    o_mean_nxt  = o_mean_r;
    o_std_nxt   = o_std_r;
    o_rate_nxt  = o_rate_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          primed_nxt = 1'b1;
          last_nxt   = in_timestamp_ns;
          x_nxt      = INTERVAL_BITS'(x_wide);
        end
      end
      S_PREP: begin
        if (count_r == '0 || x_r < min_r) min_nxt = x_r;
        if (count_r == '0 || x_r > max_r) max_nxt = x_r;
        if (count_r != '1) count_nxt = count_r + 1'b1;
        neg_nxt = (xq < mean_r);
        alu_a   = neg_nxt ? ALU_W'(mean_r) : ALU_W'(xq);
        alu_b   = neg_nxt ? ALU_W'(xq) : ALU_W'(mean_r);
        d_nxt   = MW'(alu_res);
        dq_nxt  = 64'(MW'(alu_res));
        rem_nxt = '0;
        den_nxt = 64'(count_nxt);
        cnt_nxt = DIV_LAST;
      end
      S_DIV_MEAN, S_DIV_VAR, S_DIV_RATE: begin
        alu_a   = ALU_W'(div_shift);
        alu_b   = ALU_W'(den_r);
        dq_nxt  = div_q;
        rem_nxt = div_rem;
        cnt_nxt = cnt_r - 1'b1;
        if (state_r == S_DIV_VAR && step_last) begin
          v_nxt   = div_q;
          res_nxt = '0;
          cnt_nxt = SQRT_LAST;
        end
      end
      S_MEAN: begin
        alu_a    = ALU_W'(mean_r);
        alu_b    = ALU_W'(step_q);
        alu_sub  = neg_r;
        mean_nxt = MW'(alu_res);
      end
      S_ERR: begin
        // The deviation from the new mean is the old deviation less the step.
        alu_a    = ALU_W'(d_r);
        alu_b    = ALU_W'(step_q);
        prod_nxt = {{MW{1'b0}}, MW'(alu_res)};
        cnt_nxt  = MUL_LAST;
      end
      S_MUL: begin
        alu_a    = ALU_W'(prod_r[PW-1:MW]);
        alu_b    = prod_r[0] ? ALU_W'(d_r) : '0;
        alu_sub  = 1'b0;
        prod_nxt = {alu_res[MW:0], prod_r[MW-1:1]};
        cnt_nxt  = cnt_r - 1'b1;
      end
      S_ACC: begin
        alu_a   = ALU_W'(sq_r);
        alu_b   = ALU_W'(sq_inc);
        alu_sub = 1'b0;
        sq_nxt  = sq_sat;
        dq_nxt  = sq_sat;
        rem_nxt = '0;
        den_nxt = 64'(count_r);
        cnt_nxt = DIV_LAST;
      end
      S_SQRT: begin
        alu_a = ALU_W'(v_r);
        alu_b = ALU_W'(res_r | sq_bit);
        if (!borrow) begin
          v_nxt   = alu_res[63:0];
          res_nxt = (res_r >> 1) + sq_bit;
        end else begin
          res_nxt = res_r >> 1;
        end
        cnt_nxt = cnt_r - 1'b1;
        if (step_last) begin
          std_nxt  = 32'(res_nxt);
          rate_nxt = '0;
          dq_nxt   = RATE_NUM;
          rem_nxt  = '0;
          den_nxt  = 64'(mean_r);
          cnt_nxt  = DIV_LAST;
        end
      end
      S_RATE: begin
        rate_nxt = (dq_r > RATE_MAX_MHZ) ? 40'(RATE_MAX_MHZ) : 40'(dq_r);
      end
      S_OUT: begin
        if (out_load) begin
          ov_nxt = 1'b1;
          if (count_r == '0) begin
            o_count_nxt = '0;
            o_min_nxt   = '0;
            o_max_nxt   = '0;
            o_mean_nxt  = '0;
            o_std_nxt   = '0;
            o_rate_nxt  = '0;
          end else begin
            o_count_nxt = 32'(count_r);
            o_min_nxt   = 32'(min_r);
            o_max_nxt   = 32'(max_r);
            o_mean_nxt  = 48'(mean_r);
            o_std_nxt   = std_r;
            o_rate_nxt  = rate_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      primed_r <= 1'b0;
      last_r   <= '0;
      count_r  <= '0;
      min_r    <= '0;
      max_r    <= '0;
      mean_r   <= '0;
      sq_r     <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      primed_r <= primed_nxt;
      last_r   <= last_nxt;
      count_r  <= count_nxt;
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      mean_r   <= mean_nxt;
      sq_r     <= sq_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    neg_r     <= neg_nxt;
    d_r       <= d_nxt;
    dq_r      <= dq_nxt;
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    prod_r    <= prod_nxt;
    v_r       <= v_nxt;
    res_r     <= res_nxt;
    cnt_r     <= cnt_nxt;
    std_r     <= std_nxt;
    rate_r    <= rate_nxt;
    o_count_r <= o_count_nxt;
    o_min_r   <= o_min_nxt;
    o_max_r   <= o_max_nxt;
    o_mean_r  <= o_mean_nxt;
    o_std_r   <= o_std_nxt;
    o_rate_r  <= o_rate_nxt;
  end

  assign out_valid              = ov_r;
  assign out_interval_count     = o_count_r;
  assign out_min_interval_ns    = o_min_r;
  assign out_max_interval_ns    = o_max_r;
  assign out_mean_interval      = o_mean_r;
  assign out_stddev_interval_ns = o_std_r;
  assign out_mean_rate_mhz      = o_rate_r;

  // A report with no intervals carries a zero mean, deviation and rate.
  a_zero_report: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_count_r == '0) |-> (o_mean_r == '0 && o_std_r == '0 && o_rate_r == '0))
    else $error("statistics reported without intervals");

  // Between transactions the minimum never exceeds the maximum.
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && count_r != '0) |-> (min_r <= max_r))
    else $error("minimum above maximum");

  // The running mean stays within the range of the intervals seen.
  a_mean_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && count_r != '0) |->
      (mean_r <= (MW'(max_r) << MEAN_FRAC_BITS) && mean_r >= (MW'(min_r) << MEAN_FRAC_BITS)))
    else $error("mean outside the interval range");

  // An accepted transaction always leaves the idle state.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r != S_IDLE))
    else $error("transaction accepted without starting");

endmodule
